// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/svpwm_pkg.sv =====
// shared types, constants and table function of the svpwm duty pipeline
package svpwm_pkg;

  // default sizes
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int ANGLE_BITS_DEF       = 16;

  // stream widths and field positions
  localparam int IN_W       = 48;
  localparam int OUT_W      = 64;
  localparam int VOLT_W     = 16;
  localparam int ANGLE_IN_W = 16;
  localparam int DUTY_W     = 18;
  localparam int SECTOR_W   = 3;
  localparam int VOLT_D_LSB = 0;
  localparam int VOLT_Q_LSB = 16;
  localparam int ANGLE_LSB  = 32;
  localparam int DUTY_U_LSB = 0;
  localparam int DUTY_V_LSB = 18;
  localparam int DUTY_W_LSB = 36;
  localparam int SECTOR_LSB = 54;

  // fixed-point constants
  localparam longint Q28_ONE = 64'sd268435456;
  localparam longint PI_Q28  = 64'sd843314857;
  localparam logic signed [31:0] HALF_SQRT3_Q30 = 32'sd929887697;

  // taylor divisors (2k)(2k+1) for k = 1..6
  localparam longint TAYLOR_DIV [6] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156};

  typedef logic [SECTOR_W-1:0] sector_t;

  // sector from {beta > 0, |beta| > sqrt3 |alpha|, alpha > 0}
  localparam sector_t SECTOR_OF_CODE [8] = '{3'd4, 3'd6, 3'd5, 3'd5, 3'd3, 3'd1, 3'd2, 3'd2};

  // switching pattern of each active vector, bit 0 is phase u
  localparam logic [2:0] PHASE_ON [6] = '{3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b101};

  // sin(k*60 deg) as a sign of sqrt3/2, cos(k*60 deg) in halves
  localparam logic signed [1:0] SIN_K60_SIGN [7] = '{2'sd0, 2'sd1, 2'sd1, 2'sd0,
                                                     -2'sd1, -2'sd1, 2'sd0};
  localparam logic signed [2:0] COS_K60_HALVES [7] = '{3'sd2, 3'sd1, -3'sd1, -3'sd2,
                                                       -3'sd1, 3'sd1, 3'sd2};

  // sine of a q28 angle in [-pi/2, pi/2] by taylor series, rounded to q15
  function automatic longint taylor_sin_q15(longint x);
    longint x2;
    longint term;
    longint sum;
    longint v;
    int     k;
    x2   = x * x / Q28_ONE;
    term = x;
    sum  = x;
    for (k = 0; k < 6; k++) begin
      term = -(term * x2 / Q28_ONE) / TAYLOR_DIV[k];
      sum  = sum + term;
    end
    v = sum * 64'sd32768;
    if (v >= 0) begin
      return (v + Q28_ONE / 2) / Q28_ONE;
    end else begin
      return -((-v + Q28_ONE / 2) / Q28_ONE);
    end
  endfunction

endpackage

// ===== hw/rtl/svpwm_inverse_park_duty.sv =====
// space vector pwm duty pipeline with table sine/cosine and inverse park
//
// Takes one d/q voltage command with a rotor angle per clock and returns the
// three phase duties (signed Q2.16) and the sector 1..6, one item per clock
// when the output side keeps up. In the pipeline,
// index calculation, two table reads per lookup from two constant sine
// tables (one for sine, one for cosine), interpolation, inverse park,
// sector test, active times and duty rounding each take their own register
// stages. Every stage holds its item while the stage after it is full, so a
// stalled output stops nothing until the pipeline has filled; there is no
// state between items and reset only clears the valid bits.
module svpwm_inverse_park_duty #(
  parameter int SINE_TABLE_DEPTH = svpwm_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int ANGLE_BITS       = svpwm_pkg::ANGLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // volt_d[15:0], volt_q[31:16], rotor_angle[47:32]
  input  logic [svpwm_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // duty_u[17:0], duty_v[35:18], duty_w[53:36], sector[56:54], zeros above
  output logic [svpwm_pkg::OUT_W-1:0] m_tdata
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int P_W    = ANGLE_BITS + IDX_W;
  localparam int PW     = 19 + ANGLE_BITS;
  localparam int NUM_W  = 66;
  localparam int TM_W   = NUM_W - 28;
  localparam int Q_W    = 42;
  localparam int NST    = 13;
  localparam int VW     = svpwm_pkg::VOLT_W;
  localparam int DW     = svpwm_pkg::DUTY_W;

  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(SINE_TABLE_DEPTH - 1);
  localparam logic signed [PW-1:0]    INTERP_BIAS = PW'((64'sd1 <<< ANGLE_BITS) - 64'sd1);
  localparam logic signed [NUM_W-1:0] TRUNC_BIAS  = NUM_W'((64'sd1 <<< 28) - 64'sd1);
  localparam logic signed [Q_W-1:0]   ONE_Q32     = Q_W'(64'sd1 <<< 32);
  localparam logic signed [Q_W-1:0]   HALF_Q17    = Q_W'(64'sd65536);
  localparam logic signed [Q_W-1:0]   DUTY_MAX    = Q_W'(64'sd131071);
  localparam logic signed [Q_W-1:0]   DUTY_MIN    = Q_W'(-64'sd131072);

  // sine tables, one per lookup, each read at two addresses
  logic signed [16:0] rom_a [SINE_TABLE_DEPTH];
  logic signed [16:0] rom_b [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam longint D  = longint'(SINE_TABLE_DEPTH);
    localparam longint M0 = 64'sd4 * longint'(g);
    localparam longint M1 = (M0 > 2 * D) ? M0 - 4 * D : M0;
    localparam longint M2 = (M1 > D) ? 2 * D - M1 : ((M1 < -D) ? -2 * D - M1 : M1);
    localparam longint X  = M2 * svpwm_pkg::PI_Q28 / (2 * D);
    localparam longint ENTRY = svpwm_pkg::taylor_sin_q15(X);
    assign rom_a[g] = 17'(ENTRY);
    assign rom_b[g] = 17'(ENTRY);
  end

  // stage valid bits and load enables
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  assign en[NST-1] = !v[NST-1] || m_tready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: table index and fraction for sine and cosine
  logic [ANGLE_BITS-1:0] ang_s;
  logic [ANGLE_BITS-1:0] ang_c;
  logic [P_W-1:0]        p_s;
  logic [P_W-1:0]        p_c;
  logic [IDX_W-1:0]      idx_s_next;
  logic [IDX_W-1:0]      idx_c_next;

  assign ang_s = ANGLE_BITS'(s_tdata[svpwm_pkg::ANGLE_LSB +: svpwm_pkg::ANGLE_IN_W]);
  assign ang_c = ang_s + QUARTER;
  assign p_s   = P_W'(ang_s) * P_W'(SINE_TABLE_DEPTH);
  assign p_c   = P_W'(ang_c) * P_W'(SINE_TABLE_DEPTH);
  assign idx_s_next = p_s[P_W-1:ANGLE_BITS];
  assign idx_c_next = p_c[P_W-1:ANGLE_BITS];

  logic [IDX_W-1:0]      s1_idx_s, s1_nxt_s, s1_idx_c, s1_nxt_c;
  logic [ANGLE_BITS-1:0] s1_frac_s, s1_frac_c;
  logic signed [VW-1:0]  s1_vd, s1_vq;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_idx_s  <= idx_s_next;
      s1_nxt_s  <= (idx_s_next == LAST_IDX) ? '0 : idx_s_next + IDX_W'(1);
      s1_idx_c  <= idx_c_next;
      s1_nxt_c  <= (idx_c_next == LAST_IDX) ? '0 : idx_c_next + IDX_W'(1);
      s1_frac_s <= p_s[ANGLE_BITS-1:0];
      s1_frac_c <= p_c[ANGLE_BITS-1:0];
      s1_vd     <= s_tdata[svpwm_pkg::VOLT_D_LSB +: VW];
      s1_vq     <= s_tdata[svpwm_pkg::VOLT_Q_LSB +: VW];
    end
  end

  // stage 2: table reads
  logic signed [16:0]    s2_t0s, s2_t1s, s2_t0c, s2_t1c;
  logic [ANGLE_BITS-1:0] s2_frac_s, s2_frac_c;
  logic signed [VW-1:0]  s2_vd, s2_vq;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_t0s    <= rom_a[s1_idx_s];
      s2_t1s    <= rom_a[s1_nxt_s];
      s2_t0c    <= rom_b[s1_idx_c];
      s2_t1c    <= rom_b[s1_nxt_c];
      s2_frac_s <= s1_frac_s;
      s2_frac_c <= s1_frac_c;
      s2_vd     <= s1_vd;
      s2_vq     <= s1_vq;
    end
  end

  // stage 3: slope times fraction
  logic signed [17:0]   dif_s, dif_c;
  logic signed [PW-1:0] s3_prod_s, s3_prod_c;
  logic signed [16:0]   s3_t0s, s3_t0c;
  logic signed [VW-1:0] s3_vd, s3_vq;

  assign dif_s = 18'(s2_t1s) - 18'(s2_t0s);
  assign dif_c = 18'(s2_t1c) - 18'(s2_t0c);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_prod_s <= PW'(dif_s) * PW'($signed({1'b0, s2_frac_s}));
      s3_prod_c <= PW'(dif_c) * PW'($signed({1'b0, s2_frac_c}));
      s3_t0s    <= s2_t0s;
      s3_t0c    <= s2_t0c;
      s3_vd     <= s2_vd;
      s3_vq     <= s2_vq;
    end
  end

  // stage 4: interpolated sine and cosine, step truncated toward zero
  logic signed [PW-1:0] rnd_s, rnd_c;
  logic signed [PW-1:0] q_s, q_c;
  logic signed [16:0]   s4_sn, s4_cs;
  logic signed [VW-1:0] s4_vd, s4_vq;

  assign rnd_s = s3_prod_s + (s3_prod_s[PW-1] ? INTERP_BIAS : '0);
  assign rnd_c = s3_prod_c + (s3_prod_c[PW-1] ? INTERP_BIAS : '0);
  assign q_s   = rnd_s >>> ANGLE_BITS;
  assign q_c   = rnd_c >>> ANGLE_BITS;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_sn <= 17'(18'(s3_t0s) + 18'(q_s));
      s4_cs <= 17'(18'(s3_t0c) + 18'(q_c));
      s4_vd <= s3_vd;
      s4_vq <= s3_vq;
    end
  end

  // stage 5: inverse park products
  logic signed [32:0] s5_p_dc, s5_p_qs, s5_p_ds, s5_p_qc;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_p_dc <= 33'(s4_vd) * 33'(s4_cs);
      s5_p_qs <= 33'(s4_vq) * 33'(s4_sn);
      s5_p_ds <= 33'(s4_vd) * 33'(s4_sn);
      s5_p_qc <= 33'(s4_vq) * 33'(s4_cs);
    end
  end

  // stage 6: alpha and beta in q30
  logic signed [32:0] s6_alpha, s6_beta;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_alpha <= 33'(34'(s5_p_dc) - 34'(s5_p_qs));
      s6_beta  <= 33'(34'(s5_p_ds) + 34'(s5_p_qc));
    end
  end

  // stage 7: squares for the sqrt3 test and alpha times sqrt3/2
  logic [31:0]        aa, bb;
  logic [63:0]        s7_aa2, s7_bb2;
  logic signed [63:0] s7_pa;
  logic signed [32:0] s7_alpha, s7_beta;

  assign aa = s6_alpha[32] ? 32'(-s6_alpha) : 32'(s6_alpha);
  assign bb = s6_beta[32]  ? 32'(-s6_beta)  : 32'(s6_beta);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_aa2   <= 64'(aa) * 64'(aa);
      s7_bb2   <= 64'(bb) * 64'(bb);
      s7_pa    <= 64'(s6_alpha) * 64'(svpwm_pkg::HALF_SQRT3_Q30);
      s7_alpha <= s6_alpha;
      s7_beta  <= s6_beta;
    end
  end

  // stage 8: sector
  logic                 sa, sb, sc;
  svpwm_pkg::sector_t   s8_sector;
  logic signed [63:0]   s8_pa;
  logic signed [32:0]   s8_beta;

  assign sa = !s7_beta[32] && (s7_beta != '0);
  assign sc = !s7_alpha[32] && (s7_alpha != '0);
  assign sb = 66'(s7_bb2) > (66'(s7_aa2) + (66'(s7_aa2) << 1));

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_sector <= svpwm_pkg::SECTOR_OF_CODE[{sa, sb, sc}];
      s8_pa     <= s7_pa;
      s8_beta   <= s7_beta;
    end
  end

  // stage 9: active time numerators in q60
  logic signed [NUM_W-1:0] pa_w, bt_w;
  logic signed [1:0]       sin_m, sin_n;
  logic signed [2:0]       cos_m, cos_n;
  logic signed [NUM_W-1:0] s9_tm_num, s9_tn_num;
  svpwm_pkg::sector_t      s9_sector;

  assign pa_w  = NUM_W'(s8_pa);
  assign bt_w  = NUM_W'(s8_beta) <<< 29;
  assign sin_m = svpwm_pkg::SIN_K60_SIGN[s8_sector];
  assign cos_m = svpwm_pkg::COS_K60_HALVES[s8_sector];
  assign sin_n = svpwm_pkg::SIN_K60_SIGN[s8_sector - 3'd1];
  assign cos_n = svpwm_pkg::COS_K60_HALVES[s8_sector - 3'd1];

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_tm_num <= NUM_W'(sin_m) * pa_w - NUM_W'(cos_m) * bt_w;
      s9_tn_num <= NUM_W'(cos_n) * bt_w - NUM_W'(sin_n) * pa_w;
      s9_sector <= s8_sector;
    end
  end

  // stage 10: active times truncated to q32, phase patterns
  logic signed [NUM_W-1:0] tm_r, tn_r;
  logic signed [NUM_W-1:0] tm_q, tn_q;
  logic signed [TM_W-1:0]  s10_tm, s10_tn;
  logic [2:0]              s10_on_m, s10_on_n;
  svpwm_pkg::sector_t      s10_sector;

  assign tm_r = s9_tm_num + (s9_tm_num[NUM_W-1] ? TRUNC_BIAS : '0);
  assign tn_r = s9_tn_num + (s9_tn_num[NUM_W-1] ? TRUNC_BIAS : '0);
  assign tm_q = tm_r >>> 28;
  assign tn_q = tn_r >>> 28;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s10_tm     <= TM_W'(tm_q);
      s10_tn     <= TM_W'(tn_q);
      s10_on_m   <= svpwm_pkg::PHASE_ON[s9_sector - 3'd1];
      s10_on_n   <= svpwm_pkg::PHASE_ON[(s9_sector == 3'd6) ? 3'd0 : s9_sector];
      s10_sector <= s9_sector;
    end
  end

  // stage 11: zero time and doubled active times in q33
  logic signed [Q_W-1:0] s11_t0, s11_tm2, s11_tn2;
  logic [2:0]            s11_on_m, s11_on_n;
  svpwm_pkg::sector_t    s11_sector;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s11_t0     <= ONE_Q32 - Q_W'(s10_tm) - Q_W'(s10_tn);
      s11_tm2    <= Q_W'(s10_tm) <<< 1;
      s11_tn2    <= Q_W'(s10_tn) <<< 1;
      s11_on_m   <= s10_on_m;
      s11_on_n   <= s10_on_n;
      s11_sector <= s10_sector;
    end
  end

  // stage 12: per-phase duty in q33
  logic signed [Q_W-1:0] q33_next [3];
  logic signed [Q_W-1:0] s12_q33 [3];
  svpwm_pkg::sector_t    s12_sector;

  always_comb begin
    for (int ph = 0; ph < 3; ph++) begin
      q33_next[ph] = (s11_on_m[ph] ? s11_tm2 : '0) + (s11_on_n[ph] ? s11_tn2 : '0) + s11_t0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      for (int ph = 0; ph < 3; ph++) begin
        s12_q33[ph] <= q33_next[ph];
      end
      s12_sector <= s11_sector;
    end
  end

  // stage 13: round half away from zero to q16, saturate, output register
  logic signed [Q_W-1:0] q_rnd [3];
  logic signed [Q_W-1:0] q_sh  [3];
  logic [DW-1:0]         duty  [3];

  always_comb begin
    for (int ph = 0; ph < 3; ph++) begin
      q_rnd[ph] = s12_q33[ph] + HALF_Q17 - (s12_q33[ph][Q_W-1] ? Q_W'(1) : Q_W'(0));
      q_sh[ph]  = q_rnd[ph] >>> 17;
      if (q_sh[ph] > DUTY_MAX) begin
        duty[ph] = DW'(DUTY_MAX);
      end else if (q_sh[ph] < DUTY_MIN) begin
        duty[ph] = DW'(DUTY_MIN);
      end else begin
        duty[ph] = DW'(q_sh[ph]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[12]) begin
      m_tdata <= {7'd0, s12_sector, duty[2], duty[1], duty[0]};
    end
  end

endmodule

// ===== hw/rtl/svpwm_checker.sv =====
// port-level checker for the svpwm duty pipeline and its bind
`include "assert_macros.svh"

module svpwm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [svpwm_pkg::OUT_W-1:0] m_tdata
);

  logic               out_held;
  svpwm_pkg::sector_t sector_seen;
  logic               sector_ok;

  // result waiting on the receiver, sector field of the offered item
  assign out_held    = m_tvalid && !m_tready;
  assign sector_seen = m_tdata[svpwm_pkg::SECTOR_LSB +: svpwm_pkg::SECTOR_W];
  assign sector_ok   = (sector_seen != 3'd0) && (sector_seen != 3'd7);

  // a held result stays offered and unchanged
  `ASSERT_NEXT(a_out_hold, clk, rst, out_held, m_tvalid, "result dropped while stalled")
  `ASSERT_NEXT(a_out_stable, clk, rst, out_held, $stable(m_tdata), "result changed while held")

  // reported sector is always a real sector
  `ASSERT_IMPLY(a_sector_range, clk, rst, m_tvalid, sector_ok, "sector out of range")

  // reset empties the pipeline
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid, "result offered right after reset")

  // with the output stage empty every stage can load
  `ASSERT_IMPLY(a_ready_when_drained, clk, rst, !m_tvalid, s_tready, "stall with output empty")

endmodule

bind svpwm_inverse_park_duty svpwm_checker u_svpwm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== verif/tb_svpwm_inverse_park_duty.sv =====
// self-checking testbench for the svpwm duty pipeline: stream stimulus, predicted duties
`timescale 1ns / 1ps

// q-format constants of the duty calculation
localparam int     SINE_DEPTH   = 1024;
localparam longint ANGLE_ONE    = 64'sd65536;
localparam longint Q28          = 64'sd268435456;
localparam longint PI_Q28       = 64'sd843314857;
localparam longint Q30          = 64'sd1073741824;
localparam longint ROOT3_HALF   = 64'sd929887697;
localparam longint DUTY_HI      = 64'sd131071;
localparam longint DUTY_LO      = -64'sd131072;
localparam logic [15:0] QUARTER_TURN = 16'd16384;

// sector from {beta > 0, |beta| > sqrt3 |alpha|, alpha > 0}
localparam int SECTOR_BY_SIGNS [8] = '{4, 6, 5, 5, 3, 1, 2, 2};

// phases switched high by each active vector, order u v w
localparam int VEC_PHASES [6][3] = '{'{1, 0, 0}, '{1, 1, 0}, '{0, 1, 0},
                                     '{0, 1, 1}, '{0, 0, 1}, '{1, 0, 1}};

// sin and cos of k*60 degrees in q30
localparam longint SIN60_Q30 [7] = '{0, ROOT3_HALF, ROOT3_HALF, 0,
                                     -ROOT3_HALF, -ROOT3_HALF, 0};
localparam longint COS60_Q30 [7] = '{Q30, Q30 / 2, -Q30 / 2, -Q30,
                                     -Q30 / 2, Q30 / 2, Q30};

typedef struct {
  longint u;
  longint v;
  longint w;
  longint sector_no;
} duty_set_t;

// predicts the duties of each accepted command and checks them in order
class duty_scoreboard;
  longint    sine_q15 [SINE_DEPTH];
  duty_set_t expected_duties [$];
  int        errors;

  function new();
    errors = 0;
    for (int n = 0; n < SINE_DEPTH; n++) begin
      sine_q15[n] = table_sine(n);
    end
  endfunction

  // division rounded half away from zero
  function longint half_away(longint num, longint den);
    if (num >= 0) begin
      return (num + den / 2) / den;
    end
    return -((-num + den / 2) / den);
  endfunction

  // table entry n: taylor series in q28 on the folded angle
  function longint table_sine(longint n);
    longint m;
    longint x;
    longint x2;
    longint term;
    longint acc;
    m = 4 * n;
    if (m > 2 * SINE_DEPTH) m = m - 4 * SINE_DEPTH;
    if (m > SINE_DEPTH) begin
      m = 2 * SINE_DEPTH - m;
    end else if (m < -SINE_DEPTH) begin
      m = -2 * SINE_DEPTH - m;
    end
    x    = m * PI_Q28 / (2 * SINE_DEPTH);
    x2   = x * x / Q28;
    term = x;
    acc  = x;
    for (int k = 1; k <= 6; k++) begin
      term = -(term * x2 / Q28) / longint'((2 * k) * (2 * k + 1));
      acc  = acc + term;
    end
    return half_away(acc * 32768, Q28);
  endfunction

  // interpolated sine of a 16-bit turn fraction
  function longint lookup_sine(logic [15:0] ang);
    longint p;
    longint idx;
    longint frac;
    longint s0;
    longint s1;
    p    = longint'({48'd0, ang}) * SINE_DEPTH;
    idx  = p / ANGLE_ONE;
    frac = p % ANGLE_ONE;
    s0   = sine_q15[idx];
    s1   = sine_q15[(idx + 1) % SINE_DEPTH];
    return s0 + ((s1 - s0) * frac) / ANGLE_ONE;
  endfunction

  function void note_command(logic [svpwm_pkg::IN_W-1:0] cmd);
    longint          vd;
    longint          vq;
    longint          sn;
    longint          cs;
    longint          alpha;
    longint          beta;
    longint          tm;
    longint          tn;
    longint          t0;
    longint          q33;
    longint          d;
    longint unsigned aa;
    longint unsigned bb;
    logic [15:0]     ang;
    int              sec;
    longint          duty [3];
    duty_set_t       want;
    vd    = longint'($signed(cmd[15:0]));
    vq    = longint'($signed(cmd[31:16]));
    ang   = cmd[47:32];
    sn    = lookup_sine(ang);
    cs    = lookup_sine(ang + QUARTER_TURN);
    // inverse park in q30
    alpha = vd * cs - vq * sn;
    beta  = vd * sn + vq * cs;
    aa    = (alpha < 0) ? -alpha : alpha;
    bb    = (beta < 0) ? -beta : beta;
    sec   = SECTOR_BY_SIGNS[{beta > 0, bb * bb > 64'd3 * (aa * aa), alpha > 0}];
    // active times in q32, zero time takes the rest
    tm = (SIN60_Q30[sec] * alpha - COS60_Q30[sec] * beta) / Q28;
    tn = (beta * COS60_Q30[sec - 1] - alpha * SIN60_Q30[sec - 1]) / Q28;
    t0 = 64'sd4294967296 - tm - tn;
    for (int ph = 0; ph < 3; ph++) begin
      q33 = 2 * tm * VEC_PHASES[sec - 1][ph] + 2 * tn * VEC_PHASES[sec % 6][ph] + t0;
      d   = half_away(q33, 64'sd131072);
      if (d > DUTY_HI) d = DUTY_HI;
      if (d < DUTY_LO) d = DUTY_LO;
      duty[ph] = d;
    end
    want.u         = duty[0];
    want.v         = duty[1];
    want.w         = duty[2];
    want.sector_no = sec;
    expected_duties.push_back(want);
  endfunction

  function void compare_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_duty(logic [svpwm_pkg::OUT_W-1:0] word);
    duty_set_t want;
    if (expected_duties.size() == 0) begin
      $display("%0t: duty item with none expected: expected nothing, actual %h",
               $time, word);
      errors++;
      return;
    end
    want = expected_duties.pop_front();
    compare_field("duty_u", want.u, longint'($signed(word[17:0])));
    compare_field("duty_v", want.v, longint'($signed(word[35:18])));
    compare_field("duty_w", want.w, longint'($signed(word[53:36])));
    compare_field("sector", want.sector_no, longint'(word[56:54]));
    compare_field("pad bits", 0, longint'(word[63:57]));
  endfunction

  function int pending();
    return expected_duties.size();
  endfunction
endclass

module tb_svpwm_inverse_park_duty;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [15:0] VOLT_EDGES [5] = '{16'h8000, 16'hFFFF, 16'h0000,
                                             16'h0001, 16'h7FFF};

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [svpwm_pkg::IN_W-1:0]  s_tdata;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [svpwm_pkg::OUT_W-1:0] m_tdata;

  bit tx_idle_on;
  bit rx_idle_on;
  bit rx_hold_req;

  duty_scoreboard duty_board;

  svpwm_inverse_park_duty u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // accepted items on both sides
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) duty_board.note_command(s_tdata);
    if (!rst && m_tvalid && m_tready) duty_board.check_duty(m_tdata);
  end

  // ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // output side: random stalls plus one long hold-off on request
  initial begin : receiver
    int stall;
    int hold;
    stall    = 0;
    hold     = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold        = HOLD_CYCLES - 1;
        m_tready   <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
        stall     = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [svpwm_pkg::IN_W-1:0] pack_command(logic [15:0] vd,
                                                               logic [15:0] vq,
                                                               logic [15:0] ang);
    return {ang, vq, vd};
  endfunction

  // mostly full-range commands, some small, near sector edges or at extremes
  function automatic logic [svpwm_pkg::IN_W-1:0] random_command();
    logic [15:0] vd;
    logic [15:0] vq;
    logic [15:0] ang;
    int          k;
    vd  = $urandom;
    vq  = $urandom;
    ang = $urandom;
    case ($urandom_range(0, 9))
      5, 6: begin
        vd = $urandom_range(0, 200) - 100;
        vq = $urandom_range(0, 200) - 100;
      end
      7, 8: begin
        k   = $urandom_range(0, 5);
        ang = (k * 65536) / 6 + $urandom_range(0, 8) - 4;
        vq  = $urandom_range(0, 40) - 20;
      end
      9: begin
        vd = VOLT_EDGES[$urandom_range(0, 4)];
        vq = VOLT_EDGES[$urandom_range(0, 4)];
      end
      default: ;
    endcase
    return {ang, vq, vd};
  endfunction

  // offers one command after an optional gap and waits for its handshake
  task automatic send_command(input logic [svpwm_pkg::IN_W-1:0] cmd);
    int gap;
    int r;
    gap = 0;
    if (tx_idle_on) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        gap = 0;
      end else if (r < 92) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 40);
      end
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= cmd;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_command(random_command());
    end
  endtask

  // lowers valid and waits until every predicted duty has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (duty_board.pending() != 0);
  endtask

  initial begin : stimulus
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = 1'b0;
    duty_board  = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // zero vector at several angles
    send_command(pack_command(0, 0, 0));
    send_command(pack_command(0, 0, 12345));
    send_command(pack_command(0, 0, 16'hFFFF));
    // pure d command swept through all six sectors and their edges
    send_command(pack_command(16'h7FFF, 0, 0));
    send_command(pack_command(16'h7FFF, 0, 10923));
    send_command(pack_command(16'h7FFF, 0, 16384));
    send_command(pack_command(16'h7FFF, 0, 21845));
    send_command(pack_command(16'h7FFF, 0, 32768));
    send_command(pack_command(16'h7FFF, 0, 43691));
    send_command(pack_command(16'h7FFF, 0, 49152));
    send_command(pack_command(16'h7FFF, 0, 54613));
    send_command(pack_command(16'h7FFF, 0, 16'hFFFF));
    // either side of the sqrt3 test
    send_command(pack_command(30000, 0, 10922));
    send_command(pack_command(30000, 0, 10924));
    // alpha exactly zero, then beta exactly zero
    send_command(pack_command(0, 16'h7FFF, 0));
    send_command(pack_command(-20000, 0, 0));
    // largest magnitudes, deep overmodulation
    send_command(pack_command(16'h8000, 16'h8000, 8192));
    send_command(pack_command(16'h7FFF, 16'h7FFF, 57344));
    send_command(pack_command(0, 16'h8000, 0));
    send_command(pack_command(16'h8000, 16'h7FFF, 40000));
    // tiny commands
    send_command(pack_command(1, 16'hFFFF, 1));
    send_command(pack_command(16'hFFFF, 1, 32767));

    // random with idling on both sides
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_random(250);

    // back-to-back burst into a held-off output
    tx_idle_on  = 1'b0;
    rx_hold_req = 1'b1;
    send_random(40);
    wait_drained();

    // random with no idling
    rx_idle_on = 1'b0;
    send_random(100);

    // random with idling again
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_random(210);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (duty_board.errors == 0 && duty_board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/svpwm_pkg.sv
hw/rtl/svpwm_inverse_park_duty.sv
hw/rtl/svpwm_checker.sv
verif/tb_svpwm_inverse_park_duty.sv
